/* src/vumm_pkg.sv */
// Shared types and constants for the vector unpack and mask merge block.
package vumm_pkg;

   localparam int LANE_W  = 32;
   localparam int LANES   = 4;
   localparam int HALF_W  = 64;
   localparam int INDEX_W = 8;
   localparam int DATA_W  = 32;

   typedef logic [LANE_W-1:0] lane_type;
   typedef lane_type [LANES-1:0] quad_type;

   typedef enum logic [3:0] {
      FMT_S32   = 4'd0,
      FMT_S16   = 4'd1,
      FMT_S8    = 4'd2,
      FMT_V2_32 = 4'd4,
      FMT_V2_16 = 4'd5,
      FMT_V2_8  = 4'd6,
      FMT_V3_32 = 4'd8,
      FMT_V3_16 = 4'd9,
      FMT_V3_8  = 4'd10,
      FMT_V4_32 = 4'd12,
      FMT_V4_16 = 4'd13,
      FMT_V4_8  = 4'd14,
      FMT_V4_5  = 4'd15
   } format_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_FORMAT   = 8'd0,
      REG_UNSIGNED = 8'd1,
      REG_MASK     = 8'd2
   } reg_index_type;

   typedef struct packed {
      format_type format;
      logic       unsigned_extend;
      logic       mask_enable;
   } cfg_type;

   // Source elements after widening: words, halves and bytes
   typedef struct packed {
      quad_type w;
      quad_type h;
      quad_type b;
   } elem_type;

   // Merge operands: keep_new mask and the precomputed old/force term
   typedef struct packed {
      quad_type keep_new;
      quad_type base;
   } side_type;

   function automatic lane_type widen16(logic [15:0] v, logic zext);
      return {{16{v[15] & ~zext}}, v};
   endfunction

   function automatic lane_type widen8(logic [7:0] v, logic zext);
      return {{24{v[7] & ~zext}}, v};
   endfunction

endpackage

/* src/vumm_extract.sv */
// Stage 1: split the source quadword into widened elements and prepare merge operands.
module vumm_extract (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [127:0]        source,
   input  logic [127:0]        old_val,
   input  logic [127:0]        keep_new,
   input  logic [127:0]        keep_old,
   input  logic [127:0]        force_val,
   input  logic                unsigned_extend,
   output logic                out_valid,
   input  logic                out_ready,
   output vumm_pkg::elem_type  elem,
   output vumm_pkg::side_type  side
);

   logic               valid_ff;
   vumm_pkg::elem_type elem_ff, elem_in;
   vumm_pkg::side_type side_ff, side_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign elem      = elem_ff;
   assign side      = side_ff;

   always_comb begin
      for (int i = 0; i < vumm_pkg::LANES; i++) begin
         elem_in.w[i] = source[i*32 +: 32];
         elem_in.h[i] = vumm_pkg::widen16(source[i*16 +: 16], unsigned_extend);
         elem_in.b[i] = vumm_pkg::widen8(source[i*8 +: 8], unsigned_extend);
      end
      side_in.keep_new = keep_new;
      side_in.base     = (old_val & keep_old) | force_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         elem_ff <= elem_in;
         side_ff <= side_in;
      end
   end

endmodule

/* src/vumm_select.sv */
// Stage 2: pick the four lanes for the configured format.
module vumm_select (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vumm_pkg::elem_type  elem,
   input  vumm_pkg::side_type  side_i,
   input  vumm_pkg::format_type format,
   output logic                out_valid,
   input  logic                out_ready,
   output vumm_pkg::quad_type  lanes,
   output vumm_pkg::side_type  side_o
);

   logic               valid_ff;
   vumm_pkg::quad_type lanes_ff, lanes_in;
   vumm_pkg::side_type side_ff;
   logic [15:0]        color;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign lanes     = lanes_ff;
   assign side_o    = side_ff;
   assign color     = elem.w[0][15:0];

   always_comb begin
      case (format)
         vumm_pkg::FMT_S32: lanes_in = {4{elem.w[0]}};
         vumm_pkg::FMT_S16: lanes_in = {4{elem.h[0]}};
         vumm_pkg::FMT_S8:  lanes_in = {4{elem.b[0]}};
         vumm_pkg::FMT_V2_32: lanes_in = {elem.w[1], elem.w[0], elem.w[1], elem.w[0]};
         vumm_pkg::FMT_V2_16: lanes_in = {elem.h[1], elem.h[0], elem.h[1], elem.h[0]};
         vumm_pkg::FMT_V2_8:  lanes_in = {elem.b[1], elem.b[0], elem.b[1], elem.b[0]};
         vumm_pkg::FMT_V3_32, vumm_pkg::FMT_V4_32: lanes_in = elem.w;
         vumm_pkg::FMT_V3_16, vumm_pkg::FMT_V4_16: lanes_in = elem.h;
         vumm_pkg::FMT_V3_8,  vumm_pkg::FMT_V4_8:  lanes_in = elem.b;
         vumm_pkg::FMT_V4_5: begin
            // 5:5:5:1 color to one byte per lane
            lanes_in[0] = {24'd0, color[4:0], 3'd0};
            lanes_in[1] = {24'd0, color[9:5], 3'd0};
            lanes_in[2] = {24'd0, color[14:10], 3'd0};
            lanes_in[3] = {24'd0, color[15], 7'd0};
         end
         default: lanes_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lanes_ff <= lanes_in;
         side_ff  <= side_i;
      end
   end

endmodule

/* src/vumm_merge.sv */
// Stage 3: merge the new lanes with the old destination and hold the result item.
module vumm_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vumm_pkg::quad_type  lanes,
   input  vumm_pkg::side_type  side,
   input  logic                mask_enable,
   output logic                out_valid,
   input  logic                out_ready,
   output vumm_pkg::quad_type  dest
);

   logic               valid_ff;
   vumm_pkg::quad_type dest_ff, dest_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign dest      = dest_ff;

   always_comb begin
      if (mask_enable) begin
         dest_in = (lanes & side.keep_new) | side.base;
      end else begin
         dest_in = lanes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dest_ff <= dest_in;
      end
   end

endmodule

/* src/vector_unpack_mask_merge.sv */
// Top level of the vector unpack and mask merge block.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  source, old, keep_new, keep_old, force
//   rsp      out        rsp_valid / rsp_ready  dest_low, dest_high
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// rsp_valid rises once an accepted req item has passed the extract, select and merge
// registers; one item per cycle sustained while rsp_ready stays high.
// The three stages (extract, select, merge) each have their own valid bit and
// ready is chained back stage by stage, so a stalled rsp holds its item while
// empty stages upstream still fill. Reset clears all valid bits and the
// registers (format S-32, sign extension, masking off). csr writes are always taken.
module vector_unpack_mask_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [63:0]                   req_source_low,
   input  logic [63:0]                   req_source_high,
   input  logic [63:0]                   req_old_low,
   input  logic [63:0]                   req_old_high,
   input  logic [63:0]                   req_keep_new_low,
   input  logic [63:0]                   req_keep_new_high,
   input  logic [63:0]                   req_keep_old_low,
   input  logic [63:0]                   req_keep_old_high,
   input  logic [63:0]                   req_force_low,
   input  logic [63:0]                   req_force_high,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [63:0]                   rsp_dest_low,
   output logic [63:0]                   rsp_dest_high,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vumm_pkg::INDEX_W-1:0]  csr_index,
   input  logic [vumm_pkg::DATA_W-1:0]   csr_wdata
);

   vumm_pkg::cfg_type  cfg_ff;
   vumm_pkg::elem_type elem;
   vumm_pkg::side_type side_s1, side_s2;
   vumm_pkg::quad_type lanes, dest;
   logic               s1_valid, s1_ready, s2_valid, s2_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format          <= vumm_pkg::FMT_S32;
         cfg_ff.unsigned_extend <= 1'b0;
         cfg_ff.mask_enable     <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            vumm_pkg::REG_FORMAT:   cfg_ff.format <= vumm_pkg::format_type'(csr_wdata[3:0]);
            vumm_pkg::REG_UNSIGNED: cfg_ff.unsigned_extend <= csr_wdata[0];
            vumm_pkg::REG_MASK:     cfg_ff.mask_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   vumm_extract u_extract (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .source          ({req_source_high, req_source_low}),
      .old_val         ({req_old_high, req_old_low}),
      .keep_new        ({req_keep_new_high, req_keep_new_low}),
      .keep_old        ({req_keep_old_high, req_keep_old_low}),
      .force_val       ({req_force_high, req_force_low}),
      .unsigned_extend (cfg_ff.unsigned_extend),
      .out_valid       (s1_valid),
      .out_ready       (s1_ready),
      .elem            (elem),
      .side            (side_s1)
   );

   vumm_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .elem      (elem),
      .side_i    (side_s1),
      .format    (cfg_ff.format),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .lanes     (lanes),
      .side_o    (side_s2)
   );

   vumm_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid),
      .in_ready    (s2_ready),
      .lanes       (lanes),
      .side        (side_s2),
      .mask_enable (cfg_ff.mask_enable),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .dest        (dest)
   );

   assign rsp_dest_low  = {dest[1], dest[0]};
   assign rsp_dest_high = {dest[3], dest[2]};

endmodule

/* src/vumm_checker.sv */
// Port-level checks for the vector unpack and mask merge block, with its bind.
module vumm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_dest_low,
   input logic [63:0] rsp_dest_high,
   input logic        csr_ready
);

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_low) && $stable(rsp_dest_high))
      else $error("rsp item changed while stalled");

   // An empty output stage means every stage can take an item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req stalled with room in the pipeline");

   // No result right after reset.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // Nothing reaches the output without a req item having entered the pipeline first.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid) && !$past(req_valid, 2) && !$past(req_valid, 3)
      && !$past(reset) && !$past(reset, 2) && !$past(reset, 3)
      && !$past(rsp_valid) |=> !rsp_valid || $past(req_valid, 2))
      else $error("rsp item without a req item");

   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr write refused");

endmodule

bind vector_unpack_mask_merge vumm_checker u_vumm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_dest_low  (rsp_dest_low),
   .rsp_dest_high (rsp_dest_high),
   .csr_ready     (csr_ready)
);

/* bench/tb_vector_unpack_mask_merge.sv */
// Self-checking testbench for the vector unpack and mask merge block.
module tb_vector_unpack_mask_merge;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] src_lo;
      logic [63:0] src_hi;
      logic [63:0] old_lo;
      logic [63:0] old_hi;
      logic [63:0] keep_new_lo;
      logic [63:0] keep_new_hi;
      logic [63:0] keep_old_lo;
      logic [63:0] keep_old_hi;
      logic [63:0] force_lo;
      logic [63:0] force_hi;
   } req_item_type;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
   } dest_pair_type;

   class unpack_scoreboard;
      logic [3:0]    format_code;
      logic          zero_extend;
      logic          merge_on;
      dest_pair_type expected_dests[$];
      int            errors;

      function new();
         format_code = '0;
         zero_extend = 1'b0;
         merge_on    = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(logic [vumm_pkg::INDEX_W-1:0] idx,
                              logic [vumm_pkg::DATA_W-1:0] data);
         case (idx)
            vumm_pkg::REG_FORMAT:   format_code = data[3:0];
            vumm_pkg::REG_UNSIGNED: zero_extend = data[0];
            vumm_pkg::REG_MASK:     merge_on    = data[0];
            default: ;
         endcase
      endfunction

      function dest_pair_type unpack_merge(req_item_type it);
         vumm_pkg::quad_type words;
         vumm_pkg::quad_type halves;
         vumm_pkg::quad_type bytes;
         vumm_pkg::quad_type lanes;
         logic [15:0]        half;
         logic [7:0]         octet;
         logic [15:0]        colour;
         dest_pair_type      d;
         words = {it.src_hi, it.src_lo};
         for (int i = 0; i < vumm_pkg::LANES; i++) begin
            half      = it.src_lo[16*i +: 16];
            octet     = it.src_lo[8*i +: 8];
            halves[i] = {{16{half[15] && !zero_extend}}, half};
            bytes[i]  = {{24{octet[7] && !zero_extend}}, octet};
         end
         colour = it.src_lo[15:0];
         case (format_code)
            vumm_pkg::FMT_S32:   lanes = {4{words[0]}};
            vumm_pkg::FMT_S16:   lanes = {4{halves[0]}};
            vumm_pkg::FMT_S8:    lanes = {4{bytes[0]}};
            vumm_pkg::FMT_V2_32: lanes = {words[1], words[0], words[1], words[0]};
            vumm_pkg::FMT_V2_16: lanes = {halves[1], halves[0], halves[1], halves[0]};
            vumm_pkg::FMT_V2_8:  lanes = {bytes[1], bytes[0], bytes[1], bytes[0]};
            // V3 takes a fourth element just like V4
            vumm_pkg::FMT_V3_32, vumm_pkg::FMT_V4_32: lanes = words;
            vumm_pkg::FMT_V3_16, vumm_pkg::FMT_V4_16: lanes = halves;
            vumm_pkg::FMT_V3_8, vumm_pkg::FMT_V4_8:   lanes = bytes;
            vumm_pkg::FMT_V4_5: begin
               lanes[0] = {24'd0, colour[4:0], 3'd0};
               lanes[1] = {24'd0, colour[9:5], 3'd0};
               lanes[2] = {24'd0, colour[14:10], 3'd0};
               lanes[3] = {24'd0, colour[15], 7'd0};
            end
            default: lanes = '0;
         endcase
         d.lo = {lanes[1], lanes[0]};
         d.hi = {lanes[3], lanes[2]};
         if (merge_on) begin
            d.lo = (d.lo & it.keep_new_lo) | (it.old_lo & it.keep_old_lo) | it.force_lo;
            d.hi = (d.hi & it.keep_new_hi) | (it.old_hi & it.keep_old_hi) | it.force_hi;
         end
         return d;
      endfunction

      function void note_input(req_item_type it);
         expected_dests.push_back(unpack_merge(it));
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("ERROR at %0t: %s", $realtime, msg);
      endtask

      task check_result(logic [63:0] lo, logic [63:0] hi);
         dest_pair_type want;
         if (expected_dests.size() == 0) begin
            report($sformatf("result %h_%h with no item pending", hi, lo));
         end else begin
            want = expected_dests.pop_front();
            if (lo !== want.lo)
               report($sformatf("dest_low got %h want %h", lo, want.lo));
            if (hi !== want.hi)
               report($sformatf("dest_high got %h want %h", hi, want.hi));
         end
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   req_item_type                  offer = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [63:0]                   rsp_dest_low;
   logic [63:0]                   rsp_dest_high;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [vumm_pkg::INDEX_W-1:0]  csr_index = '0;
   logic [vumm_pkg::DATA_W-1:0]   csr_wdata = '0;

   unpack_scoreboard    sb = new();
   bit                  calm = 1'b0;
   bit                  hold_pending = 1'b0;
   int                  stall_left = 0;

   vector_unpack_mask_merge dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_low    (offer.src_lo),
      .req_source_high   (offer.src_hi),
      .req_old_low       (offer.old_lo),
      .req_old_high      (offer.old_hi),
      .req_keep_new_low  (offer.keep_new_lo),
      .req_keep_new_high (offer.keep_new_hi),
      .req_keep_old_low  (offer.keep_old_lo),
      .req_keep_old_high (offer.keep_old_hi),
      .req_force_low     (offer.force_lo),
      .req_force_high    (offer.force_hi),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dest_low      (rsp_dest_low),
      .rsp_dest_high     (rsp_dest_high),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [63:0] random_word();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      it.src_lo      = random_word();
      it.src_hi      = random_word();
      it.old_lo      = random_word();
      it.old_hi      = random_word();
      it.keep_new_lo = random_word();
      it.keep_new_hi = random_word();
      it.keep_old_lo = random_word();
      it.keep_old_hi = random_word();
      it.force_lo    = random_word();
      it.force_hi    = random_word();
      return it;
   endfunction

   // Observe all three channels at the edge where handshakes complete
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) sb.note_input(offer);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_dest_low, rsp_dest_high);
      end
   end

   // Result side back-pressure, with one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_pending) begin
         hold_pending = 1'b0;
         stall_left = 80;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic offer_item(input req_item_type it);
      req_valid <= 1'b1;
      offer <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [vumm_pkg::INDEX_W-1:0] idx,
                            input logic [vumm_pkg::DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Upper data bits are random so that the register width cut is exercised
   task automatic set_config(input logic [3:0] fmt, input logic zext, input logic merge,
                             input bit stray);
      write_csr(vumm_pkg::REG_FORMAT, ($urandom & ~32'hF) | fmt);
      write_csr(vumm_pkg::REG_UNSIGNED, ($urandom & ~32'h1) | zext);
      if (stray) write_csr(vumm_pkg::INDEX_W'($urandom_range(3, 255)), $urandom);
      write_csr(vumm_pkg::REG_MASK, ($urandom & ~32'h1) | merge);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_phase(input int count, input bit no_gaps);
      int gap;
      for (int n = 0; n < count; n++) begin
         offer_item(random_item());
         gap = no_gaps ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Let the last accepted item be noted, hold until every expected result
   // is back, then let the pipeline settle
   task automatic drain();
      @(posedge clock);
      while (sb.expected_dests.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      req_item_type it;
      int           sent;
      int           count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: plain S-32 with sign extension
      it = '0;
      offer_item(it);
      offer_item('1);
      req_valid <= 1'b0;
      drain();

      // One item per format code, reserved ones included
      for (int f = 0; f < 16; f++) begin
         set_config(4'(f), f[2], 1'b0, f == 0 || f == 15);
         it = random_item();
         it.src_lo = f[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_8000_807F_7F80;
         it.src_hi = ~it.src_lo;
         offer_item(it);
         req_valid <= 1'b0;
         drain();
      end

      // Merge corner cases
      set_config(vumm_pkg::FMT_V4_32, 1'b1, 1'b1, 1'b0);
      offer_item('0);
      offer_item('1);
      it = '0;
      it.src_lo = random_word();
      it.src_hi = random_word();
      it.keep_new_lo = '1;
      it.keep_new_hi = '1;
      offer_item(it);
      it = '0;
      it.src_lo = '1;
      it.src_hi = '1;
      it.old_lo = random_word();
      it.old_hi = random_word();
      it.keep_old_lo = '1;
      it.keep_old_hi = '1;
      offer_item(it);
      it = '0;
      it.force_lo = '1;
      it.force_hi = '1;
      offer_item(it);
      offer_item(random_item());
      req_valid <= 1'b0;
      drain();

      // Fill the pipeline against a long receiver hold
      set_config(4'($urandom_range(0, 15)), 1'($urandom), 1'b1, 1'b0);
      calm = 1'b1;
      hold_pending = 1'b1;
      send_phase(40, 1'b1);
      drain();
      calm = 1'b0;

      sent = 40;
      while (sent < 500) begin
         set_config(4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
                    $urandom_range(0, 3) == 0);
         calm = ($urandom_range(0, 3) == 0);
         count = $urandom_range(10, 40);
         send_phase(count, calm);
         drain();
         calm = 1'b0;
         sent += count;
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_dests.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
